FILE: rtl/gqv_pkg.sv
// ----------------------------------------------------------------------------
// Glyph quad vertex generator package
// Command codes, register indexes and field widths of the glyph stream.
// ----------------------------------------------------------------------------
package gqv_pkg;

	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_GLYPH   = 2'd1,
		CMD_MISSING = 2'd2,
		CMD_EOF     = 2'd3
	} cmd_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 26;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH    = 3'd0,
		REG_NDC_SCALE_X    = 3'd1,
		REG_NDC_SCALE_Y    = 3'd2,
		REG_INV_TEX_WIDTH  = 3'd3,
		REG_INV_TEX_HEIGHT = 3'd4,
		REG_LINE_HEIGHT    = 3'd5
	} reg_index_t;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 80;

	localparam logic [12:0] FRAME_WIDTH_RST    = 13'd1024;
	localparam logic [25:0] NDC_SCALE_X_RST    = 26'd32768;
	localparam logic [25:0] NDC_SCALE_Y_RST    = 26'd32768;
	localparam logic [24:0] INV_TEX_WIDTH_RST  = 25'd65536;
	localparam logic [24:0] INV_TEX_HEIGHT_RST = 25'd65536;
	localparam logic [7:0]  LINE_HEIGHT_RST    = 8'd14;

	localparam logic [1:0] CORNER_LAST = 2'd3;

endpackage

FILE: rtl/glyph_quad_vertex_generator.sv
// ----------------------------------------------------------------------------
// Glyph quad vertex generator
// Turns glyph commands into four textured corner vertices per found glyph.
// ----------------------------------------------------------------------------
// A found glyph is held in stage-1 registers; each vertex is registered for output.
// Throughput: one vertex per cycle while the output is not stalled, set by the single
// vertex datapath; begin, missing and end words never occupy that datapath.
// The next word is taken while the fourth vertex leaves.
// Reset: pen, line start and vertex counter clear; registers take defaults.
// ----------------------------------------------------------------------------
module glyph_quad_vertex_generator
	import gqv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// origin_x, origin_y, glyph_width, glyph_height, tex_x, tex_y
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// command
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// ndc_x, ndc_y, tex_u, tex_v, vertex_index
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// corner
	output logic [1:0]             m_tuser,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [12:0] frame_width_q;
	logic [25:0] ndc_scale_x_q;
	logic [25:0] ndc_scale_y_q;
	logic [24:0] inv_tex_width_q;
	logic [24:0] inv_tex_height_q;
	logic [7:0]  line_height_q;

	logic [15:0]        pen_x_q;
	logic signed [15:0] pen_y_q;
	logic [11:0]        line_start_x_q;
	logic [15:0]        vertex_count_q;

	logic               busy_s1;
	logic [1:0]         corner_s1;
	logic [15:0]        px_s1;
	logic signed [15:0] py_s1;
	logic [7:0]         gw_s1;
	logic [7:0]         gh_s1;
	logic [11:0]        tx_s1;
	logic [11:0]        ty_s1;
	logic [15:0]        vbase_s1;

	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [1:0]  out_corner_q;
	logic        out_last_q;

	cmd_t        in_cmd;
	logic [11:0] in_ox, in_oy, in_tx, in_ty;
	logic [7:0]  in_gw, in_gh;
	logic        in_fire, adv, adv_last;

	logic [15:0]        nx;
	logic signed [16:0] ny;
	logic signed [15:0] ny_sat;

	logic                cx, cy;
	logic [16:0]         vx;
	logic signed [16:0]  vy;
	logic [12:0]         tu, tv;
	logic [42:0]         prod_x;
	logic signed [43:0]  prod_y;
	logic [37:0]         prod_u, prod_v;
	logic signed [35:0]  ndc_x_w;
	logic signed [35:0]  ndc_y_w;
	logic signed [44:0]  rnd_y;
	logic [43:0]         rnd_x;
	logic [29:0]         tu_q, tv_q;
	logic [15:0]         ndc_x_sat, ndc_y_sat, tex_u_sat, tex_v_sat;

	assign in_cmd = cmd_t'(s_tuser);
	assign in_ox  = s_tdata[11:0];
	assign in_oy  = s_tdata[23:12];
	assign in_gw  = s_tdata[31:24];
	assign in_gh  = s_tdata[39:32];
	assign in_tx  = s_tdata[51:40];
	assign in_ty  = s_tdata[63:52];

	assign adv      = busy_s1 && (!out_valid_q || m_tready);
	assign adv_last = adv && (corner_s1 == CORNER_LAST);
	assign s_tready = !busy_s1 || adv_last;
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// pen advance and wrap
	always_comb begin
		nx = pen_x_q + {8'd0, in_gw};
		ny = {pen_y_q[15], pen_y_q} - $signed({9'd0, line_height_q});
		if (ny < -17'sd32768) begin
			ny_sat = -16'sd32768;
		end else begin
			ny_sat = ny[15:0];
		end
	end

	// vertex datapath
	always_comb begin
		cx = corner_s1[0];
		cy = corner_s1[1];
		vx = {1'b0, px_s1} + (cx ? {9'd0, gw_s1} : 17'd0);
		vy = {py_s1[15], py_s1} - (cy ? $signed({8'd0, gh_s1} + 17'd1) : 17'sd0);
		tu = {1'b0, tx_s1} + (cx ? {5'd0, gw_s1} : 13'd0);
		tv = {1'b0, ty_s1} + (cy ? ({5'd0, gh_s1} + 13'd1) : 13'd0);

		prod_x = {26'd0, vx} * {17'd0, ndc_scale_x_q};
		prod_y = {{27{vy[16]}}, vy} * $signed({18'd0, ndc_scale_y_q});
		prod_u = {25'd0, tu} * {13'd0, inv_tex_width_q};
		prod_v = {25'd0, tv} * {13'd0, inv_tex_height_q};

		rnd_x   = {1'b0, prod_x} + 44'd512;
		ndc_x_w = $signed({2'b00, rnd_x[43:10]}) - 36'sd16384;
		rnd_y   = {prod_y[43], prod_y} + 45'sd512;
		ndc_y_w = $signed(rnd_y[44:10]) + 36'sd16384;
		tu_q    = 30'((prod_u + 38'd128) >> 8);
		tv_q    = 30'((prod_v + 38'd128) >> 8);

		if (ndc_x_w > 36'sd32767) begin
			ndc_x_sat = 16'h7FFF;
		end else if (ndc_x_w < -36'sd32768) begin
			ndc_x_sat = 16'h8000;
		end else begin
			ndc_x_sat = ndc_x_w[15:0];
		end
		if (ndc_y_w > 36'sd32767) begin
			ndc_y_sat = 16'h7FFF;
		end else if (ndc_y_w < -36'sd32768) begin
			ndc_y_sat = 16'h8000;
		end else begin
			ndc_y_sat = ndc_y_w[15:0];
		end
		tex_u_sat = (tu_q > 30'd65535) ? 16'hFFFF : tu_q[15:0];
		tex_v_sat = (tv_q > 30'd65535) ? 16'hFFFF : tv_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FRAME_WIDTH_RST;
			ndc_scale_x_q    <= NDC_SCALE_X_RST;
			ndc_scale_y_q    <= NDC_SCALE_Y_RST;
			inv_tex_width_q  <= INV_TEX_WIDTH_RST;
			inv_tex_height_q <= INV_TEX_HEIGHT_RST;
			line_height_q    <= LINE_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[12:0];
				REG_NDC_SCALE_X:    ndc_scale_x_q    <= cfg_data[25:0];
				REG_NDC_SCALE_Y:    ndc_scale_y_q    <= cfg_data[25:0];
				REG_INV_TEX_WIDTH:  inv_tex_width_q  <= cfg_data[24:0];
				REG_INV_TEX_HEIGHT: inv_tex_height_q <= cfg_data[24:0];
				REG_LINE_HEIGHT:    line_height_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// pen state and vertex counter, updated as each word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q        <= '0;
			pen_y_q        <= '0;
			line_start_x_q <= '0;
			vertex_count_q <= '0;
		end else if (in_fire) begin
			case (in_cmd)
				CMD_BEGIN: begin
					pen_x_q        <= {4'd0, in_ox};
					line_start_x_q <= in_ox;
					pen_y_q        <= -$signed({4'd0, in_oy});
				end
				CMD_GLYPH: begin
					vertex_count_q <= vertex_count_q + 16'd4;
					if (nx >= {3'd0, frame_width_q}) begin
						pen_x_q <= {4'd0, line_start_x_q};
						pen_y_q <= ny_sat;
					end else begin
						pen_x_q <= nx;
					end
				end
				CMD_MISSING: vertex_count_q <= vertex_count_q + 16'd4;
				default: vertex_count_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			corner_s1 <= '0;
		end else if (in_fire && in_cmd == CMD_GLYPH) begin
			busy_s1   <= 1'b1;
			corner_s1 <= '0;
		end else if (adv_last) begin
			busy_s1   <= 1'b0;
			corner_s1 <= '0;
		end else if (adv) begin
			corner_s1 <= corner_s1 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_cmd == CMD_GLYPH) begin
			px_s1    <= pen_x_q;
			py_s1    <= pen_y_q;
			gw_s1    <= in_gw;
			gh_s1    <= in_gh;
			tx_s1    <= in_tx;
			ty_s1    <= in_ty;
			vbase_s1 <= vertex_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q   <= {vbase_s1 + {14'd0, corner_s1}, tex_v_sat, tex_u_sat,
				ndc_y_sat, ndc_x_sat};
			out_corner_q <= corner_s1;
			out_last_q   <= (corner_s1 == CORNER_LAST);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_corner_q;
	assign m_tlast  = out_last_q;

	a_last_on_final_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == CORNER_LAST)))
		else $error("last flag out of step with corner");

	a_ready_only_at_quad_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && busy_s1 |-> corner_s1 == CORNER_LAST && adv)
		else $error("word taken while a quad is still in flight");

	a_quad_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> busy_s1 && corner_s1 == m_tuser + 2'd1)
		else $error("vertex sequence of a quad broken");

	a_pen_y_not_up: assert property (@(posedge clk) disable iff (!arst_n)
		pen_y_q[15] || pen_y_q == 16'sd0)
		else $error("pen y above origin line");

	a_idle_corner_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_s1 |-> corner_s1 == 2'd0)
		else $error("corner counter running while idle");

endmodule
